// File: design/frequency_droop_power_setpoint_assert.svh
// Assertion macros used by the checker file of the droop setpoint block.
// No dependencies; included by bare file name.
`ifndef FREQUENCY_DROOP_POWER_SETPOINT_ASSERT_SVH
`define FREQUENCY_DROOP_POWER_SETPOINT_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define FDPS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define FDPS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/fdps_pkg.sv
// Package for the frequency droop power setpoint block: widths, codes,
// constants, controller states and the command/status structs. No dependencies.
package fdps_pkg;

    localparam int OP_W     = 2;
    localparam int VAL_W    = 17;
    localparam int PWR_W    = 16;
    localparam int SET_W    = 23;
    localparam int ADDR_W   = 4;
    localparam int DATA_W   = 32;
    localparam int SLOPE_W  = 13;    // buffer_length / 10
    localparam int NUM_W    = 33;    // |d| * k
    localparam int THIRDS_W = 44;    // signed sum in thirds of a hundredth
    localparam int CLAMP_W  = 25;    // clamped sum, never negative
    localparam int DIV_STEPS = 33;
    localparam int CNT_W    = 6;

    // operation codes
    localparam logic [OP_W-1:0] OP_TICK   = 2'd0;
    localparam logic [OP_W-1:0] OP_FREQ   = 2'd1;
    localparam logic [OP_W-1:0] OP_FRAMES = 2'd2;

    // register indexes (paddr[3:2])
    localparam logic [1:0] REG_DEADLINE = 2'd0;
    localparam logic [1:0] REG_MAX_PWR  = 2'd1;
    localparam logic [1:0] REG_MIN_PWR  = 2'd2;
    localparam logic [1:0] REG_BUF_LEN  = 2'd3;

    localparam logic [VAL_W-1:0] FREQ_NOMINAL  = 17'd60000;
    localparam logic [VAL_W-1:0] FRAMES_RESET  = 17'd1;

    // x / 10 = (x * 52429) >> 19, exact for 16-bit x
    localparam logic [15:0] DIV10_MUL   = 16'd52429;
    localparam int          DIV10_SHIFT = 19;
    // x / 3 = (x * 44739243) >> 27, exact for x below 2^25
    localparam logic [25:0] DIV3_MUL    = 26'd44739243;
    localparam int          DIV3_SHIFT  = 27;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_MUL1,
        ST_MUL2,
        ST_DIV,
        ST_SUM1,
        ST_SUM2,
        ST_CLAMP,
        ST_ROUND,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic accept;
        logic prep;
        logic mul1;
        logic mul2;
        logic div_step;
        logic sum1;
        logic sum2;
        logic clamp;
        logic round;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic out_busy;
    } t_stat;

    typedef struct packed {
        logic             deadline_en;
        logic [PWR_W-1:0] max_power;
        logic [PWR_W-1:0] min_power;
        logic [PWR_W-1:0] buffer_length;
    } t_cfg;

endpackage

// File: design/fdps_regs.sv
// APB register file of the droop setpoint block (four registers at 4*i).
// Depends on fdps_pkg.
module fdps_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [fdps_pkg::ADDR_W-1:0]  paddr,
    input  logic [fdps_pkg::DATA_W-1:0]  pwdata,
    output logic [fdps_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    output fdps_pkg::t_cfg               o_cfg
);
    import fdps_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                REG_DEADLINE: r_cfg.deadline_en   <= pwdata[0];
                REG_MAX_PWR:  r_cfg.max_power     <= pwdata[PWR_W-1:0];
                REG_MIN_PWR:  r_cfg.min_power     <= pwdata[PWR_W-1:0];
                REG_BUF_LEN:  r_cfg.buffer_length <= pwdata[PWR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_DEADLINE: prdata = {{(DATA_W-1){1'b0}}, r_cfg.deadline_en};
            REG_MAX_PWR:  prdata = {{(DATA_W-PWR_W){1'b0}}, r_cfg.max_power};
            REG_MIN_PWR:  prdata = {{(DATA_W-PWR_W){1'b0}}, r_cfg.min_power};
            REG_BUF_LEN:  prdata = {{(DATA_W-PWR_W){1'b0}}, r_cfg.buffer_length};
            default:      prdata = '0;
        endcase
    end

    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

endmodule

// File: design/fdps_ctrl.sv
// Sequencer of the droop setpoint block: steps the datapath through one item.
// Depends on fdps_pkg.
module fdps_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  fdps_pkg::t_stat i_stat,
    output logic            o_in_ready,
    output fdps_pkg::t_cmd  o_cmd
);
    import fdps_pkg::*;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = ST_PREP;
                end
            end
            ST_PREP: begin
                o_cmd.prep = 1'b1;
                n_state    = ST_MUL1;
            end
            ST_MUL1: begin
                o_cmd.mul1 = 1'b1;
                n_state    = ST_MUL2;
            end
            ST_MUL2: begin
                o_cmd.mul2 = 1'b1;
                n_cnt      = '0;
                n_state    = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_state = ST_SUM1;
                end
            end
            ST_SUM1: begin
                o_cmd.sum1 = 1'b1;
                n_state    = ST_SUM2;
            end
            ST_SUM2: begin
                o_cmd.sum2 = 1'b1;
                n_state    = ST_CLAMP;
            end
            ST_CLAMP: begin
                o_cmd.clamp = 1'b1;
                n_state     = ST_ROUND;
            end
            ST_ROUND: begin
                o_cmd.round = 1'b1;
                n_state     = ST_DONE;
            end
            ST_DONE: begin
                // wait for the output register to free up
                if (!i_stat.out_busy) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_in_ready = (r_state == ST_IDLE);

endmodule

// File: design/fdps_dp.sv
// Datapath of the droop setpoint block: held state, droop and offset terms,
// serial divider, clamp, rounding and output register. Depends on fdps_pkg.
module fdps_dp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  fdps_pkg::t_cmd              i_cmd,
    input  fdps_pkg::t_cfg              i_cfg,
    input  logic [fdps_pkg::OP_W-1:0]   i_operation,
    input  logic [fdps_pkg::VAL_W-1:0]  i_value,
    input  logic                        i_out_ready,
    output fdps_pkg::t_stat             o_stat,
    output logic                        o_out_valid,
    output logic [fdps_pkg::SET_W-1:0]  o_setpoint
);
    import fdps_pkg::*;

    // held state
    logic [VAL_W-1:0] r_freq;
    logic [VAL_W-1:0] r_frames;

    // prep stage
    logic signed [VAL_W-1:0] r_d;          // max - min
    logic signed [VAL_W:0]   r_df;         // freq - 60000
    logic [SLOPE_W-1:0]      r_slope;
    logic [CLAMP_W-1:0]      r_base;       // 150 * (max + min)
    logic [CLAMP_W-1:0]      r_hi300;
    logic [CLAMP_W-1:0]      r_lo300;

    // mul1 stage
    logic signed [34:0]      r_droop;
    logic [VAL_W-1:0]        r_k;
    logic [PWR_W-1:0]        r_absd;
    logic                    r_neg;
    logic                    r_ramp;

    // mul2 / divider
    logic signed [37:0]      r_droop5;
    logic [NUM_W-1:0]        r_num;
    logic [SLOPE_W-1:0]      r_rem;

    // sum / clamp / round
    logic signed [THIRDS_W-1:0] r_acc;
    logic signed [THIRDS_W-1:0] r_off300;
    logic signed [THIRDS_W-1:0] r_thirds;
    logic [CLAMP_W:0]           r_clamped;  // clamped + 1
    logic [51:0]                r_prod3;

    logic               r_out_valid;
    logic [SET_W-1:0]   r_setpoint;

    // combinational helpers
    logic [31:0]                w_slope_prod;
    logic [VAL_W-1:0]           w_sum;
    logic [CLAMP_W-1:0]         w_sum25;
    logic [CLAMP_W-1:0]         w_hi25;
    logic [CLAMP_W-1:0]         w_lo25;
    logic [PWR_W-1:0]           w_thr;
    logic                       w_full;
    logic                       w_empty;
    logic signed [VAL_W-1:0]    w_negd;
    logic signed [37:0]         w_droop_x;
    logic [SLOPE_W:0]           w_trial;
    logic                       w_ge;
    logic signed [NUM_W:0]      w_q;
    logic signed [THIRDS_W-1:0] w_off;
    logic signed [THIRDS_W-1:0] w_base44;
    logic signed [THIRDS_W-1:0] w_hi44;
    logic signed [THIRDS_W-1:0] w_lo44;
    logic signed [THIRDS_W-1:0] w_t1;
    logic signed [THIRDS_W-1:0] w_t2;

    assign w_slope_prod = 32'(i_cfg.buffer_length) * 32'(DIV10_MUL);
    assign w_sum   = {1'b0, i_cfg.max_power} + {1'b0, i_cfg.min_power};
    assign w_sum25 = CLAMP_W'(w_sum);
    assign w_hi25  = CLAMP_W'(i_cfg.max_power);
    assign w_lo25  = CLAMP_W'(i_cfg.min_power);

    // ramp regions of the frame buffer
    assign w_thr   = i_cfg.buffer_length - PWR_W'(r_slope);
    assign w_full  = r_frames > {1'b0, w_thr};
    assign w_empty = r_frames < VAL_W'(r_slope);
    assign w_negd  = -r_d;

    assign w_droop_x = 38'(r_droop);

    // restoring divider, one quotient bit per step
    assign w_trial = {r_rem, r_num[NUM_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_slope};

    assign w_q   = $signed({1'b0, r_num});
    assign w_off = !r_ramp ? '0 : (r_neg ? THIRDS_W'(-w_q) : THIRDS_W'(w_q));

    assign w_base44 = $signed(THIRDS_W'(r_base));
    assign w_hi44   = $signed(THIRDS_W'(r_hi300));
    assign w_lo44   = $signed(THIRDS_W'(r_lo300));
    assign w_t1     = (r_thirds > w_hi44) ? w_hi44 : r_thirds;
    assign w_t2     = (w_t1 < w_lo44) ? w_lo44 : w_t1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_freq   <= FREQ_NOMINAL;
            r_frames <= FRAMES_RESET;
        end else if (i_cmd.accept) begin
            if (i_operation == OP_FREQ) begin
                r_freq <= i_value;
            end else if (i_operation == OP_FRAMES && i_value != '0) begin
                r_frames <= i_value;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.prep) begin
            r_d     <= $signed({1'b0, i_cfg.max_power}) - $signed({1'b0, i_cfg.min_power});
            r_df    <= $signed({1'b0, r_freq}) - $signed({1'b0, FREQ_NOMINAL});
            r_slope <= w_slope_prod[DIV10_SHIFT +: SLOPE_W];
            // 150 = 128 + 16 + 4 + 2, 300 = 256 + 32 + 8 + 4
            r_base  <= (w_sum25 << 7) + (w_sum25 << 4) + (w_sum25 << 2) + (w_sum25 << 1);
            r_hi300 <= (w_hi25 << 8) + (w_hi25 << 5) + (w_hi25 << 3) + (w_hi25 << 2);
            r_lo300 <= (w_lo25 << 8) + (w_lo25 << 5) + (w_lo25 << 3) + (w_lo25 << 2);
        end
        if (i_cmd.mul1) begin
            r_droop <= 35'(r_d) * 35'(r_df);
            r_k     <= w_full ? (r_frames - {1'b0, w_thr}) : (VAL_W'(r_slope) - r_frames);
            r_absd  <= r_d[VAL_W-1] ? w_negd[PWR_W-1:0] : r_d[PWR_W-1:0];
            r_neg   <= w_full ^ r_d[VAL_W-1];
            r_ramp  <= i_cfg.deadline_en && (r_slope != '0) && (w_full || w_empty);
        end
        if (i_cmd.mul2) begin
            r_droop5 <= (w_droop_x <<< 2) + w_droop_x;
            r_num    <= NUM_W'(r_absd) * NUM_W'(r_k);
            r_rem    <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem <= w_ge ? SLOPE_W'(w_trial - {1'b0, r_slope}) : w_trial[SLOPE_W-1:0];
            r_num <= {r_num[NUM_W-2:0], w_ge};
        end
        if (i_cmd.sum1) begin
            r_acc    <= w_base44 + THIRDS_W'(r_droop5);
            r_off300 <= (w_off <<< 8) + (w_off <<< 5) + (w_off <<< 3) + (w_off <<< 2);
        end
        if (i_cmd.sum2) begin
            r_thirds <= r_acc + r_off300;
        end
        if (i_cmd.clamp) begin
            r_clamped <= {1'b0, w_t2[CLAMP_W-1:0]} + 26'd1;
        end
        if (i_cmd.round) begin
            r_prod3 <= 52'(r_clamped) * 52'(DIV3_MUL);
        end
        if (i_cmd.load_out) begin
            r_setpoint <= r_prod3[DIV3_SHIFT +: SET_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_stat.out_busy = r_out_valid && !i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_setpoint      = r_setpoint;

endmodule

// File: design/frequency_droop_power_setpoint.sv
// Frequency droop power setpoint. Each transfer on the input channel is a
// tick, a new grid frequency in millihertz or a new buffered frame count
// (a count of zero is ignored); each yields one setpoint in hundredths of a
// unit: mid-range of [min_power, max_power] plus the droop term
// (max-min)*(freq-60000)/60, plus, in deadline mode, a buffer-occupancy
// offset (max-min)*k/slope truncated toward zero, slope = buffer_length/10,
// then clamped to max_power and after that to min_power, rounded to nearest.
// The result enters the output register after prep, two multiplies, the 33
// steps of the restoring divider that forms the offset, two sums, clamp and
// round; the input is ready again the cycle after, also while that result
// waits, so items are taken one at a time. A result still unread when the next
// is done holds the sequencer in its last step until the receiver takes it.
// Depends on fdps_pkg, fdps_regs, fdps_ctrl and fdps_dp.
module frequency_droop_power_setpoint (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // input channel
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [fdps_pkg::OP_W-1:0]    i_operation,
    input  logic [fdps_pkg::VAL_W-1:0]   i_value,
    // result channel
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [fdps_pkg::SET_W-1:0]   o_setpoint,
    // configuration port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [fdps_pkg::ADDR_W-1:0]  paddr,
    input  logic [fdps_pkg::DATA_W-1:0]  pwdata,
    output logic [fdps_pkg::DATA_W-1:0]  prdata,
    output logic                         pready
);
    import fdps_pkg::*;

    t_cfg  w_cfg;
    t_cmd  w_cmd;
    t_stat w_stat;

    // Registers: 0 deadline enable, 1 max power, 2 min power, 3 buffer length.
    fdps_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Sequencer: idle -> prep -> two multiply steps -> 33 divide steps ->
    // two sum steps -> clamp -> round -> load output register.
    fdps_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_stat     (w_stat),
        .o_in_ready (o_ready),
        .o_cmd      (w_cmd)
    );

    // Datapath works in thirds of a hundredth so the droop term is exact;
    // the final /3 is a reciprocal multiply.
    fdps_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_cfg       (w_cfg),
        .i_operation (i_operation),
        .i_value     (i_value),
        .i_out_ready (i_ready),
        .o_stat      (w_stat),
        .o_out_valid (o_valid),
        .o_setpoint  (o_setpoint)
    );

endmodule

// File: design/fdps_checker.sv
// Port-level checks for the droop setpoint block, bound to the top level.
// Depends on fdps_pkg and frequency_droop_power_setpoint_assert.svh.
`include "frequency_droop_power_setpoint_assert.svh"

module fdps_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_valid,
    input logic                        o_ready,
    input logic                        o_valid,
    input logic                        i_ready,
    input logic [fdps_pkg::SET_W-1:0]  o_setpoint
);
    import fdps_pkg::*;

    // one item in work at a time
    `FDPS_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, i_valid && o_ready, !o_ready, "input taken while an item is in work")

    // a stalled result holds
    `FDPS_ASSERT_NXT(a_hold_result, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_setpoint), "stalled result changed")

    // clamp keeps the setpoint within 100 * 65535
    `FDPS_ASSERT_IMP(a_setpoint_range, i_clk, i_rst_n, o_valid, o_setpoint <= SET_W'(6553500), "setpoint above full scale")

endmodule

bind frequency_droop_power_setpoint fdps_checker u_fdps_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_valid    (i_valid),
    .o_ready    (o_ready),
    .o_valid    (o_valid),
    .i_ready    (i_ready),
    .o_setpoint (o_setpoint)
);
